FILE: hdl/c1d_pkg.sv
// ---------------------------------------------------------------------------
// c1d_pkg: shared types and constants for the 1-D convolution block
// Word formats for the input and result channels, the issue word that the
// sequencer hands to the datapath, and the coefficient row layout.
// ---------------------------------------------------------------------------
package c1d_pkg;

    // Default size of the filter bank
    localparam int FILTER_COUNT_DEF = 10;
    localparam int TAP_COUNT        = 3;

    // Field widths
    localparam int IDX_W    = 5;
    localparam int COEF_W   = 16;
    localparam int SAMPLE_W = 16;
    localparam int FEAT_W   = 16;
    localparam int FIDX_W   = 4;
    localparam int TAP_W    = 2;
    localparam int ROW_W    = TAP_COUNT * COEF_W;
    localparam int PROD_W   = COEF_W + SAMPLE_W + 1;
    localparam int SUM_W    = PROD_W + 2;

    // Item modes
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // Round half up before dropping the 15 fraction bits
    localparam int RND_SHIFT = 15;

    // Input word
    typedef struct packed {
        logic                       mode;
        logic [IDX_W-1:0]           coef_index;
        logic signed [COEF_W-1:0]   coef_value;
        logic [SAMPLE_W-1:0]        sample;
        logic                       end_of_row;
    } in_t;

    // Result word
    typedef struct packed {
        logic [FIDX_W-1:0]          filter_index;
        logic [FEAT_W-1:0]          feature;
        logic                       row_end;
        logic                       last;
    } out_t;

    // One issued operation: a coefficient load or one filter evaluation
    typedef struct packed {
        logic                       valid;
        logic                       is_load;
        logic [TAP_W-1:0]           tap;
        logic signed [COEF_W-1:0]   value;
        logic [SAMPLE_W-1:0]        a;
        logic [SAMPLE_W-1:0]        b;
        logic [SAMPLE_W-1:0]        c;
        logic                       row_end;
        logic                       last;
    } iss_t;

    // Coefficient index / 3 for 5-bit indexes: (x * 43) >> 7
    function automatic logic [FIDX_W-1:0] div3(input logic [IDX_W-1:0] x);
        logic [10:0] p;
        p = 11'(x) * 11'd43;
        return p[10:7];
    endfunction

endpackage

FILE: hdl/conv1d_same_relu_single_channel_top.sv
// ---------------------------------------------------------------------------
// conv1d_same_relu_single_channel_top: 3-tap same-padded conv with ReLU
// Input words load coefficients (mode 0) or deliver row samples (mode 1);
// result words carry one filter output each.
//
// Usage:
//   item_*  valid/ready input channel, one in_t word per handshake.
//   feat_*  valid/ready result channel, one out_t word per handshake.
//   A coefficient load issues one read-modify-write of a filter row. A
//   sample that closes no position issues nothing; otherwise it issues
//   FILTER_COUNT row reads per position it closes (one, or up to two at a
//   row end), one filter row read from the coefficient RAM per cycle on
//   its single read port while the datapath is not stalled. Results pass the
//   product, sum and output registers, one per cycle while feat_ready is high.
//   Reset clears the row history and all pipeline valids; coefficients are
//   undefined until loaded, there is no clearing pass.
//   When feat_ready is low the pipeline fills, then item_ready drops; no
//   word is lost or repeated.
// ---------------------------------------------------------------------------
module conv1d_same_relu_single_channel_top #(
    parameter int FILTER_COUNT = c1d_pkg::FILTER_COUNT_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  c1d_pkg::in_t    item,
    output logic            feat_valid,
    input  logic            feat_ready,
    output c1d_pkg::out_t   feat
);

    localparam int FILT_W = (FILTER_COUNT > 1) ? $clog2(FILTER_COUNT) : 1;

    c1d_pkg::iss_t                  iss;
    logic [FILT_W-1:0]              iss_filter;
    logic                           iss_ready;
    logic [c1d_pkg::ROW_W-1:0]      rd_data;
    logic                           we;
    logic [FILT_W-1:0]              waddr;
    logic [c1d_pkg::ROW_W-1:0]      wdata;

    // Input and sequencer
    c1d_seq #(
        .FILTER_COUNT(FILTER_COUNT)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .iss_ready  (iss_ready),
        .iss        (iss),
        .iss_filter (iss_filter)
    );

    // Coefficient store, one row of taps per filter
    c1d_ram #(
        .WIDTH(c1d_pkg::ROW_W),
        .DEPTH(FILTER_COUNT)
    ) u_coef_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (iss_ready),
        .raddr (iss_filter),
        .rdata (rd_data)
    );

    // Datapath and output word
    c1d_mac #(
        .FILTER_COUNT(FILTER_COUNT)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .iss        (iss),
        .iss_filter (iss_filter),
        .iss_ready  (iss_ready),
        .rd_data    (rd_data),
        .we         (we),
        .waddr      (waddr),
        .wdata      (wdata),
        .feat_valid (feat_valid),
        .feat_ready (feat_ready),
        .feat       (feat)
    );

endmodule

FILE: hdl/c1d_ram.sv
// ---------------------------------------------------------------------------
// c1d_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module c1d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                    wdata,
    input  logic                                re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                    rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/c1d_seq.sv
// ---------------------------------------------------------------------------
// c1d_seq: input stage, row state and issue sequencer
// Takes input words, tracks the two previous samples of the row and steps
// through the filter bank, issuing one coefficient-row read per cycle while iss_ready is high.
// ---------------------------------------------------------------------------
module c1d_seq #(
    parameter int FILTER_COUNT = c1d_pkg::FILTER_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  c1d_pkg::in_t        item,
    input  logic                iss_ready,
    output c1d_pkg::iss_t       iss,
    output logic [(FILTER_COUNT > 1 ? $clog2(FILTER_COUNT) : 1)-1:0] iss_filter
);

    localparam int FILT_W = (FILTER_COUNT > 1) ? $clog2(FILTER_COUNT) : 1;

    // Control state
    logic              busy_reg, busy_next;
    logic              is_load_reg;
    logic              phase_reg, phase_next;
    logic [FILT_W-1:0] cnt_reg, cnt_next;
    logic              has2_reg;
    logic              inside_reg;
    logic [c1d_pkg::SAMPLE_W-1:0] prev_reg, sbp_reg;

    // Held payload of the current word
    logic                               ld_ok_reg;
    logic [c1d_pkg::FIDX_W-1:0]         ld_q_reg;
    logic [c1d_pkg::TAP_W-1:0]          ld_tap_reg;
    logic signed [c1d_pkg::COEF_W-1:0]  ld_value_reg;
    logic [c1d_pkg::SAMPLE_W-1:0]       pa_reg, pb_reg, pc_reg;

    logic                               acc;
    logic                               is_sample;
    logic [c1d_pkg::FIDX_W-1:0]         q_in;
    logic                               cnt_last;
    logic                               do_issue;
    logic                               final_step;
    logic                               step;
    logic                               fin;

    assign acc       = item_valid && item_ready;
    assign is_sample = (item.mode == c1d_pkg::MODE_SAMPLE);
    assign q_in      = c1d_pkg::div3(item.coef_index);
    assign cnt_last  = (cnt_reg == FILT_W'(FILTER_COUNT - 1));

    // Issue decision for the current word
    always_comb
    begin
        if (is_load_reg)
        begin
            do_issue   = busy_reg && ld_ok_reg;
            final_step = 1'b1;
        end
        else
        begin
            do_issue   = busy_reg && (phase_reg ? has2_reg : 1'b1);
            final_step = !do_issue || (cnt_last && (phase_reg || !has2_reg));
        end
    end

    assign step       = busy_reg && (!do_issue || iss_ready);
    assign fin        = step && final_step;
    assign item_ready = !busy_reg || fin;

    // Issue word
    always_comb
    begin
        iss.valid   = do_issue;
        iss.is_load = is_load_reg;
        iss.tap     = ld_tap_reg;
        iss.value   = ld_value_reg;
        iss.a       = phase_reg ? pb_reg : pa_reg;
        iss.b       = phase_reg ? pc_reg : pb_reg;
        iss.c       = phase_reg ? '0 : pc_reg;
        iss.row_end = phase_reg;
        iss.last    = cnt_last && (phase_reg || !has2_reg);
        iss_filter  = is_load_reg ? FILT_W'(ld_q_reg) : cnt_reg;
    end

    // Sequencer next state
    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        if (fin)
        begin
            busy_next = 1'b0;
        end
        if (step && do_issue && !is_load_reg)
        begin
            if (cnt_last)
            begin
                cnt_next   = '0;
                phase_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        if (acc)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            phase_next = !inside_reg;
        end
    end

    // Control registers and row state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            is_load_reg <= 1'b0;
            phase_reg   <= 1'b0;
            cnt_reg     <= '0;
            has2_reg    <= 1'b0;
            inside_reg  <= 1'b0;
            prev_reg    <= '0;
            sbp_reg     <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            if (acc)
            begin
                is_load_reg <= !is_sample;
                has2_reg    <= item.end_of_row;
                if (is_sample)
                begin
                    if (item.end_of_row)
                    begin
                        inside_reg <= 1'b0;
                        prev_reg   <= '0;
                        sbp_reg    <= '0;
                    end
                    else
                    begin
                        inside_reg <= 1'b1;
                        prev_reg   <= item.sample;
                        sbp_reg    <= prev_reg;
                    end
                end
            end
        end
    end

    // Payload of the accepted word
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            ld_ok_reg    <= (32'(item.coef_index) < FILTER_COUNT * c1d_pkg::TAP_COUNT);
            ld_q_reg     <= q_in;
            ld_tap_reg   <= c1d_pkg::TAP_W'(item.coef_index - 5'(q_in * 3));
            ld_value_reg <= item.coef_value;
            pa_reg       <= sbp_reg;
            pb_reg       <= prev_reg;
            pc_reg       <= item.sample;
        end
    end

    // Row end clears both sample registers
    a_row_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && is_sample && item.end_of_row)
        |=> (!inside_reg && prev_reg == '0 && sbp_reg == '0))
        else $error("row state not cleared after row end");

    // A sample inside a row shifts into the history
    a_row_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && is_sample && !item.end_of_row)
        |=> (inside_reg && prev_reg == $past(item.sample) && sbp_reg == $past(prev_reg)))
        else $error("sample history not shifted");

    // Sweep counter never passes the bank size
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (32'(cnt_reg) < FILTER_COUNT))
        else $error("filter counter out of range");

endmodule

FILE: hdl/c1d_mac.sv
// ---------------------------------------------------------------------------
// c1d_mac: coefficient read-modify-write and filter datapath
// Stage 1 takes the RAM row (with write forwarding) and either merges a
// coefficient load or feeds the multipliers; then products, sum, and the
// ReLU / round / saturate into the output word register.
// ---------------------------------------------------------------------------
module c1d_mac #(
    parameter int FILTER_COUNT = c1d_pkg::FILTER_COUNT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  c1d_pkg::iss_t               iss,
    input  logic [(FILTER_COUNT > 1 ? $clog2(FILTER_COUNT) : 1)-1:0] iss_filter,
    output logic                        iss_ready,
    input  logic [c1d_pkg::ROW_W-1:0]   rd_data,
    output logic                        we,
    output logic [(FILTER_COUNT > 1 ? $clog2(FILTER_COUNT) : 1)-1:0] waddr,
    output logic [c1d_pkg::ROW_W-1:0]   wdata,
    output logic                        feat_valid,
    input  logic                        feat_ready,
    output c1d_pkg::out_t               feat
);

    localparam int FILT_W = (FILTER_COUNT > 1) ? $clog2(FILTER_COUNT) : 1;
    localparam int CW     = c1d_pkg::COEF_W;
    localparam int PW     = c1d_pkg::PROD_W;
    localparam int SW     = c1d_pkg::SUM_W;

    // Stage valids
    logic v1_reg, v2_reg, v3_reg, vo_reg;

    // Stage payloads
    c1d_pkg::iss_t                  s1_reg;
    logic [FILT_W-1:0]              f1_reg, f2_reg, f3_reg;
    logic signed [PW-1:0]           p0_reg, p1_reg, p2_reg;
    logic                           re2_reg, ls2_reg, re3_reg, ls3_reg;
    logic signed [SW-1:0]           sum_reg;
    c1d_pkg::out_t                  feat_reg;

    // Forwarding of the write made in the cycle of the read
    logic                           fwd_v_reg;
    logic [FILT_W-1:0]              fwd_addr_reg;
    logic [c1d_pkg::ROW_W-1:0]      fwd_data_reg;

    logic [c1d_pkg::ROW_W-1:0]      row;
    logic                           en_o, en3, en2, en1;
    logic signed [SW-1:0]           rnd;
    logic [SW-c1d_pkg::RND_SHIFT-1:0] shr;
    logic [c1d_pkg::FEAT_W-1:0]     feat_val;

    // Hold-up chain, back to front
    assign en_o      = !vo_reg || feat_ready;
    assign en3       = !v3_reg || en_o;
    assign en2       = !v2_reg || en3;
    assign en1       = !v1_reg || s1_reg.is_load || en2;
    assign iss_ready = en1;

    assign row = (fwd_v_reg && fwd_addr_reg == f1_reg) ? fwd_data_reg : rd_data;

    // Coefficient load: replace one tap of the row
    always_comb
    begin
        wdata = row;
        for (int t = 0; t < c1d_pkg::TAP_COUNT; t++)
        begin
            if (s1_reg.tap == c1d_pkg::TAP_W'(t))
            begin
                wdata[t*CW +: CW] = s1_reg.value;
            end
        end
    end

    assign we    = v1_reg && s1_reg.is_load;
    assign waddr = f1_reg;

    // ReLU, round half up, saturate
    always_comb
    begin
        rnd = sum_reg + SW'(1 << (c1d_pkg::RND_SHIFT - 1));
        shr = rnd[SW-1:c1d_pkg::RND_SHIFT];
        if (sum_reg[SW-1] || sum_reg == '0)
        begin
            feat_val = '0;
        end
        else if (|shr[SW-c1d_pkg::RND_SHIFT-1:c1d_pkg::FEAT_W])
        begin
            feat_val = '1;
        end
        else
        begin
            feat_val = shr[c1d_pkg::FEAT_W-1:0];
        end
    end

    // Stage valids and forward register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            vo_reg    <= 1'b0;
            fwd_v_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg    <= iss.valid;
                fwd_v_reg <= we;
            end
            if (en2)
            begin
                v2_reg <= v1_reg && !s1_reg.is_load;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en_o)
            begin
                vo_reg <= v3_reg;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_reg       <= iss;
            f1_reg       <= iss_filter;
            fwd_addr_reg <= waddr;
            fwd_data_reg <= wdata;
        end
        if (en2)
        begin
            p0_reg  <= $signed(row[0*CW +: CW]) * $signed({1'b0, s1_reg.a});
            p1_reg  <= $signed(row[1*CW +: CW]) * $signed({1'b0, s1_reg.b});
            p2_reg  <= $signed(row[2*CW +: CW]) * $signed({1'b0, s1_reg.c});
            f2_reg  <= f1_reg;
            re2_reg <= s1_reg.row_end;
            ls2_reg <= s1_reg.last;
        end
        if (en3)
        begin
            sum_reg <= SW'(p0_reg) + SW'(p1_reg) + SW'(p2_reg);
            f3_reg  <= f2_reg;
            re3_reg <= re2_reg;
            ls3_reg <= ls2_reg;
        end
        if (en_o)
        begin
            feat_reg.filter_index <= c1d_pkg::FIDX_W'(f3_reg);
            feat_reg.feature      <= feat_val;
            feat_reg.row_end      <= re3_reg;
            feat_reg.last         <= ls3_reg;
        end
    end

    assign feat_valid = vo_reg;
    assign feat       = feat_reg;

    // The closing word of an input word comes from the top filter
    a_last_filter: assert property (@(posedge clk) disable iff (!rst_n)
        (feat_valid && feat.last)
        |-> (feat.filter_index == c1d_pkg::FIDX_W'(FILTER_COUNT - 1)))
        else $error("last flag on a filter other than the top one");

    // A stalled sum stage keeps its value
    a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !en_o) |=> (v3_reg && $stable(sum_reg)))
        else $error("sum stage changed while stalled");

    // Stage 1 never stalls while it holds a load
    a_load_once: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> en1)
        else $error("coefficient load blocked in stage 1");

endmodule
